@@ rtl/seomf_pkg.sv @@
`timescale 1ns / 1ps

package seomf_pkg;

  localparam int WINDOW    = 5;
  localparam int FRAC_BITS = 4;

  localparam int ECHO_W  = 16;
  localparam int DIST_W  = 13;
  localparam int CM_W    = 9;
  localparam int RT_W    = 7;
  localparam int BLIM_W  = 8;
  localparam int OLIM_W  = 4;
  localparam int CFG_W   = 9;
  localparam int CIDX_W  = 3;
  localparam int DIV_W   = ECHO_W + FRAC_BITS;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef logic [DIST_W-1:0] dist_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_MAX_DIST,
    REG_ROUND_TRIP,
    REG_NEAR_ZONE,
    REG_MAX_JUMP,
    REG_BLIND_LIMIT,
    REG_BLIND_FILL,
    REG_OUTLIER_LIMIT
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CLEAN,
    ST_MED,
    ST_OUT
  } state_t;

  // whole cm to 1/16 cm, saturated
  function automatic dist_t scale_cm(logic [CM_W-1:0] cm);
    logic [31:0] w;
    w = 32'(cm) << FRAC_BITS;
    return (w > 32'(DIST_MAX)) ? DIST_MAX : w[DIST_W-1:0];
  endfunction

endpackage

@@ rtl/seomf_divider.sv @@
`timescale 1ns / 1ps

module seomf_divider import seomf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [RT_W-1:0]  divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_W);
  localparam int REM_W = RT_W + 1;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [REM_W-1:0] rem;
  logic [DIV_W-1:0] quot;
  logic [REM_W-1:0] trial;
  logic [REM_W-1:0] rem_next;
  logic             qbit;

  // one restoring step per cycle, dividend bits shift out as quotient bits shift in
  always_comb begin
    trial    = {rem[REM_W-2:0], quot[DIV_W-1]};
    qbit     = trial >= {1'b0, divisor};
    rem_next = qbit ? trial - {1'b0, divisor} : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= dividend;
    end else if (busy) begin
      rem  <= rem_next;
      quot <= {quot[DIV_W-2:0], qbit};
    end
  end

  assign quotient = quot;

endmodule

@@ rtl/seomf_median.sv @@
`timescale 1ns / 1ps

module seomf_median import seomf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  dist_t sample,
  output logic  done,
  output dist_t median
);

  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SLOT_W = $clog2(WINDOW);

  dist_t             win [WINDOW];
  logic [FILL_W-1:0] fill;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] cand;
  logic              busy;
  dist_t             cval;
  logic [FILL_W-1:0] lt_cnt;
  logic [FILL_W-1:0] le_cnt;
  logic [FILL_W-1:0] mid;
  logic              found;

  // rank test of one candidate per cycle against all filled entries
  always_comb begin
    cval   = win[cand];
    lt_cnt = '0;
    le_cnt = '0;
    for (int j = 0; j < WINDOW; j++) begin
      if (FILL_W'(j) < fill) begin
        if (win[j] < cval)  lt_cnt = lt_cnt + FILL_W'(1);
        if (win[j] <= cval) le_cnt = le_cnt + FILL_W'(1);
      end
    end
    mid   = fill >> 1;
    found = (lt_cnt <= mid) && (le_cnt > mid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      slot <= '0;
      cand <= '0;
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (wr) begin
        slot <= (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + SLOT_W'(1);
        if (fill < FILL_W'(WINDOW)) fill <= fill + FILL_W'(1);
        cand <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (found) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else if (cand != SLOT_W'(WINDOW - 1)) begin
          cand <= cand + SLOT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) win[slot] <= sample;
    if (busy && found) median <= cval;
  end

endmodule

@@ rtl/sonar_echo_outlier_median_filter_unit.sv @@
`timescale 1ns / 1ps

// sonar echo cleaner with outlier rejection and running median
// input channel: in_valid / in_ready with echo_us, echo time in us (0 = no echo)
// output channel: out_valid / out_ready with median_distance and cleaned_distance,
//   both in 1/16 cm
// config channel: cfg_valid / cfg_ready (always ready), cfg_index selects the
//   register, cfg_data is truncated to the register width; write only while idle
// one request at a time: the echo is converted by a restoring divider, one quotient
//   bit per cycle, then cleaned in the ST_CLEAN state, then the median is found by
//   testing one window entry per cycle until the median entry is found
// in_ready returns in the same cycle as out_valid, so a new request is taken only
//   after the result of the last one is loaded into the output register
// a result that is not taken holds in the output register; the next request is
//   accepted meanwhile, and its result waits until the output register is free
// reset clears the filter state and window count and restores the register
//   defaults; no clearing pass is needed

module sonar_echo_outlier_median_filter_unit import seomf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ECHO_W-1:0] echo_us,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DIST_W-1:0] median_distance,
  output logic [DIST_W-1:0] cleaned_distance,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  state_t state, state_next;

  logic [CM_W-1:0]   max_distance_cm;
  logic [RT_W-1:0]   round_trip_us_per_cm;
  logic [CM_W-1:0]   near_zone_cm;
  logic [CM_W-1:0]   max_jump_cm;
  logic [BLIM_W-1:0] blind_streak_limit;
  logic [CM_W-1:0]   blind_fill_cm;
  logic [OLIM_W-1:0] outlier_streak_limit;

  dist_t             last_accepted, last_accepted_next;
  logic [BLIM_W-1:0] blind_streak, blind_streak_next;
  logic [OLIM_W-1:0] outlier_streak, outlier_streak_next;
  logic              echo_zero;
  dist_t             cleaned, cleaned_next;

  logic              div_start;
  logic              div_done;
  logic [DIV_W-1:0]  quotient;
  logic              med_wr;
  logic              med_done;
  dist_t             med_value;
  logic              out_load;

  seomf_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({echo_us, FRAC_BITS'(0)}),
    .divisor  (round_trip_us_per_cm),
    .done     (div_done),
    .quotient (quotient)
  );

  seomf_median u_med (
    .clk    (clk),
    .rst    (rst),
    .wr     (med_wr),
    .sample (cleaned_next),
    .done   (med_done),
    .median (med_value)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_distance_cm      <= CM_W'(400);
      round_trip_us_per_cm <= RT_W'(57);
      near_zone_cm         <= CM_W'(25);
      max_jump_cm          <= CM_W'(15);
      blind_streak_limit   <= BLIM_W'(15);
      blind_fill_cm        <= CM_W'(2);
      outlier_streak_limit <= OLIM_W'(4);
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_MAX_DIST:      max_distance_cm      <= cfg_data[CM_W-1:0];
        REG_ROUND_TRIP:    round_trip_us_per_cm <= cfg_data[RT_W-1:0];
        REG_NEAR_ZONE:     near_zone_cm         <= cfg_data[CM_W-1:0];
        REG_MAX_JUMP:      max_jump_cm          <= cfg_data[CM_W-1:0];
        REG_BLIND_LIMIT:   blind_streak_limit   <= cfg_data[BLIM_W-1:0];
        REG_BLIND_FILL:    blind_fill_cm        <= cfg_data[CM_W-1:0];
        REG_OUTLIER_LIMIT: outlier_streak_limit <= cfg_data[OLIM_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    med_wr     = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        div_start = in_valid;
        if (in_valid) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_next = ST_CLEAN;
      end
      ST_CLEAN: begin
        med_wr     = 1'b1;
        state_next = ST_MED;
      end
      ST_MED: begin
        if (med_done) state_next = ST_OUT;
      end
      ST_OUT: begin
        out_load = !out_valid || out_ready;
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // blind-spot and jump filtering
  always_comb begin
    dist_t             max_d;
    dist_t             near_d;
    dist_t             jump_d;
    dist_t             fill_d;
    dist_t             conv;
    dist_t             raw;
    dist_t             delta;
    logic [BLIM_W-1:0] bs_inc;
    logic [OLIM_W-1:0] os_inc;

    max_d  = scale_cm(max_distance_cm);
    near_d = scale_cm(near_zone_cm);
    jump_d = scale_cm(max_jump_cm);
    fill_d = scale_cm(blind_fill_cm);

    if (round_trip_us_per_cm == '0)
      conv = DIST_MAX;
    else if (32'(quotient) > 32'(DIST_MAX))
      conv = DIST_MAX;
    else
      conv = DIST_W'(quotient);

    bs_inc = (blind_streak == {BLIM_W{1'b1}}) ? blind_streak : blind_streak + BLIM_W'(1);

    if (echo_zero) begin
      if ((last_accepted != '0) && (last_accepted < near_d)) begin
        blind_streak_next = bs_inc;
        raw = (bs_inc < blind_streak_limit) ? fill_d : max_d;
      end else begin
        blind_streak_next = '0;
        raw = max_d;
      end
    end else begin
      blind_streak_next = '0;
      raw = conv;
    end

    delta  = (raw >= last_accepted) ? raw - last_accepted : last_accepted - raw;
    os_inc = outlier_streak + OLIM_W'(1);

    cleaned_next        = raw;
    last_accepted_next  = raw;
    outlier_streak_next = '0;
    if ((last_accepted != '0) && (delta > jump_d) && (raw >= last_accepted)) begin
      // upward jump: hold the last level until the streak reaches the limit
      if (os_inc < outlier_streak_limit) begin
        cleaned_next        = last_accepted;
        last_accepted_next  = last_accepted;
        outlier_streak_next = os_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_accepted  <= '0;
      blind_streak   <= '0;
      outlier_streak <= '0;
    end else if (med_wr) begin
      last_accepted  <= last_accepted_next;
      blind_streak   <= blind_streak_next;
      outlier_streak <= outlier_streak_next;
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) echo_zero <= (echo_us == '0);
    if (med_wr)    cleaned   <= cleaned_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      median_distance  <= med_value;
      cleaned_distance <= cleaned;
    end
  end

endmodule
